>>> rtl/pnsh_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and types of the polyline hit test.
package pnsh_pkg;

	// coordinates are signed with 4 fraction bits (1/16 pixel)
	localparam int COORD_W   = 20;
	localparam int DIFF_W    = COORD_W + 1;   // b - a, q - a
	localparam int MAG_W     = COORD_W;       // magnitude of a difference
	localparam int PROD_W    = 2 * MAG_W;
	localparam int LEN_W     = PROD_W + 1;    // len2 and dist_sq
	localparam int DOT_W     = LEN_W + 1;     // signed dot product

	// projection parameter t in Q1.16, so that 1.0 (T_ONE) fits
	localparam int T_FRAC    = 16;
	localparam int T_W       = T_FRAC + 1;
	localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;
	localparam logic [PROD_W-1:0] T_ROUND = PROD_W'((1 << T_FRAC) - 1);

	// serial multiplier digit
	localparam int DIGIT_W   = 4;
	localparam int MUL_STEPS = MAG_W / DIGIT_W;
	localparam int NLANE     = 4;

	// hit threshold in 1/16 pixel: max(HIT_MIN, width) + HIT_PAD
	localparam int LW_W      = 10;
	localparam int TH_W      = LW_W + 1;
	localparam int THSQ_W    = 2 * TH_W;
	localparam int HIT_MIN   = 64;
	localparam int HIT_PAD   = 64;
	localparam logic [LW_W-1:0] LW_RESET = LW_W'(16);

	localparam int SEG_W          = 16;
	localparam int SEG_LIMIT      = 1 << SEG_W;
	localparam int DEF_MAX_POINTS = 65536;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = LW_W;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 1'd1;

	// input item kinds
	localparam logic MODE_START  = 1'b0;
	localparam logic MODE_VERTEX = 1'b1;

	// one segment to evaluate against the query point
	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic signed [COORD_W-1:0] qx;
		logic signed [COORD_W-1:0] qy;
	} seg_req_t;

endpackage

>>> rtl/pnsh_ser_mul.sv
`timescale 1ns / 1ps
// Digit-serial unsigned multiplier, one multiplier digit per cycle, LSB first.
module pnsh_ser_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pnsh_pkg::MAG_W-1:0]    a,
	input  logic [pnsh_pkg::MAG_W-1:0]    b,
	output logic                          done,
	output logic [pnsh_pkg::PROD_W-1:0]   prod
);

	localparam int MW   = pnsh_pkg::MAG_W;
	localparam int DW   = pnsh_pkg::DIGIT_W;
	localparam int CNTW = $clog2(pnsh_pkg::MUL_STEPS + 1);

	logic [MW-1:0]    a_q;
	logic [MW-1:0]    hi_q;
	logic [MW-1:0]    lo_q;   // remaining multiplier digits below, product digits shifting in at the top
	logic [CNTW-1:0]  cnt_q;
	logic             done_q;
	logic [MW+DW-1:0] sum;

	assign sum = (MW+DW)'(hi_q) + (MW+DW)'(a_q) * (MW+DW)'(lo_q[DW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNTW'(pnsh_pkg::MUL_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (cnt_q != '0) begin
			hi_q <= sum[MW+DW-1:DW];
			lo_q <= {sum[DW-1:0], lo_q[MW-1:DW]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

>>> rtl/pnsh_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider for the Q0.16 projection parameter.
module pnsh_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pnsh_pkg::LEN_W-1:0]   num,   // must be below den
	input  logic [pnsh_pkg::LEN_W-1:0]   den,
	output logic                         done,
	output logic [pnsh_pkg::T_FRAC-1:0]  quo
);

	localparam int LW   = pnsh_pkg::LEN_W;
	localparam int QW   = pnsh_pkg::T_FRAC;
	localparam int CNTW = $clog2(QW + 1);

	logic [LW-1:0]   rem_q;
	logic [QW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [LW:0]     shifted;
	logic [LW:0]     diff;
	logic            ge;

	assign shifted = {rem_q, 1'b0};
	assign ge      = shifted >= {1'b0, den};
	assign diff    = shifted - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNTW'(QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
		end else if (cnt_q != '0) begin
			// remainder stays below den, so it fits LW bits either way
			rem_q <= ge ? diff[LW-1:0] : shifted[LW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> rtl/pnsh_seg_eval.sv
`timescale 1ns / 1ps
// Squared distance from the query point to one segment, sequenced over shared serial units.
module pnsh_seg_eval (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  pnsh_pkg::seg_req_t          req,
	output logic                        done,
	output logic [pnsh_pkg::LEN_W-1:0]  dist_sq
);

	localparam int DW  = pnsh_pkg::DIFF_W;
	localparam int MW  = pnsh_pkg::MAG_W;
	localparam int PW  = pnsh_pkg::PROD_W;
	localparam int LW  = pnsh_pkg::LEN_W;
	localparam int OW  = pnsh_pkg::DOT_W;
	localparam int NL  = pnsh_pkg::NLANE;
	localparam int TF  = pnsh_pkg::T_FRAC;

	typedef enum logic [3:0] {
		S_IDLE, S_DIFF, S_MUL1, S_DOT, S_PICK, S_DIV, S_MUL2, S_DELTA, S_MUL3
	} state_t;

	function automatic logic [MW-1:0] mag_of(input logic signed [DW-1:0] v);
		logic [DW-1:0] n;
		n = v[DW-1] ? DW'(-v) : DW'(v);
		return n[MW-1:0];
	endfunction

	// floor(ab * t / 2^16) magnitude; negative ab rounds the magnitude up
	function automatic logic [MW-1:0] off_of(input logic [PW-1:0] p, input logic neg);
		logic [PW-1:0] s;
		s = neg ? p + pnsh_pkg::T_ROUND : p;
		return s[TF+MW-1:TF];
	endfunction

	state_t             state_q;
	pnsh_pkg::seg_req_t req_q;
	logic               mul_start_q;
	logic               div_start_q;
	logic [MW-1:0]      op_a_q [NL];
	logic [MW-1:0]      op_b_q [NL];
	logic [PW-1:0]      prod   [NL];
	logic [NL-1:0]      mul_done;
	logic               div_done;
	logic [TF-1:0]      quo;

	logic               abx_neg_q, aby_neg_q, t2_neg_q, t3_neg_q;
	logic [MW-1:0]      mabx_q, maby_q;
	logic signed [DW-1:0] dqx_q, dqy_q;
	logic [LW-1:0]      len2_q;
	logic signed [OW-1:0] term2_q, term3_q, dot_q;
	logic [MW-1:0]      offx_q, offy_q;
	logic [LW-1:0]      dist_q;
	logic               done_q;

	logic signed [DW-1:0] abx_c, aby_c, dqx_c, dqy_c, dx_c, dy_c;
	logic                 dot_pos;

	assign abx_c = DW'(req_q.bx) - DW'(req_q.ax);
	assign aby_c = DW'(req_q.by) - DW'(req_q.ay);
	assign dqx_c = DW'(req_q.qx) - DW'(req_q.ax);
	assign dqy_c = DW'(req_q.qy) - DW'(req_q.ay);
	// q - c = (q - a) - offset
	assign dx_c  = abx_neg_q ? dqx_q + DW'(offx_q) : dqx_q - DW'(offx_q);
	assign dy_c  = aby_neg_q ? dqy_q + DW'(offy_q) : dqy_q - DW'(offy_q);
	assign dot_pos = !dot_q[OW-1] && (dot_q != '0);

	for (genvar i = 0; i < NL; i++) begin : g_lane
		pnsh_ser_mul u_mul (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (mul_start_q),
			.a      (op_a_q[i]),
			.b      (op_b_q[i]),
			.done   (mul_done[i]),
			.prod   (prod[i])
		);
	end

	pnsh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (dot_q[LW-1:0]),
		.den    (len2_q),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			done_q      <= 1'b0;
			dist_q      <= '0;
			abx_neg_q   <= 1'b0;
			aby_neg_q   <= 1'b0;
			t2_neg_q    <= 1'b0;
			t3_neg_q    <= 1'b0;
			mabx_q      <= '0;
			maby_q      <= '0;
			dqx_q       <= '0;
			dqy_q       <= '0;
			len2_q      <= '0;
			term2_q     <= '0;
			term3_q     <= '0;
			dot_q       <= '0;
			offx_q      <= '0;
			offy_q      <= '0;
			for (int i = 0; i < NL; i++) begin
				op_a_q[i] <= '0;
				op_b_q[i] <= '0;
			end
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			done_q      <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req;
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					abx_neg_q   <= abx_c[DW-1];
					aby_neg_q   <= aby_c[DW-1];
					t2_neg_q    <= abx_c[DW-1] ^ dqx_c[DW-1];
					t3_neg_q    <= aby_c[DW-1] ^ dqy_c[DW-1];
					mabx_q      <= mag_of(abx_c);
					maby_q      <= mag_of(aby_c);
					dqx_q       <= dqx_c;
					dqy_q       <= dqy_c;
					op_a_q[0]   <= mag_of(abx_c);
					op_b_q[0]   <= mag_of(abx_c);
					op_a_q[1]   <= mag_of(aby_c);
					op_b_q[1]   <= mag_of(aby_c);
					op_a_q[2]   <= mag_of(dqx_c);
					op_b_q[2]   <= mag_of(abx_c);
					op_a_q[3]   <= mag_of(dqy_c);
					op_b_q[3]   <= mag_of(aby_c);
					mul_start_q <= 1'b1;
					state_q     <= S_MUL1;
				end
				S_MUL1: begin
					if (&mul_done) begin
						len2_q  <= LW'(prod[0]) + LW'(prod[1]);
						term2_q <= t2_neg_q ? -OW'(prod[2]) : OW'(prod[2]);
						term3_q <= t3_neg_q ? -OW'(prod[3]) : OW'(prod[3]);
						state_q <= S_DOT;
					end
				end
				S_DOT: begin
					dot_q   <= term2_q + term3_q;
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (len2_q == '0 || !dot_pos) begin
						op_a_q[0]   <= mabx_q;
						op_b_q[0]   <= '0;
						op_a_q[1]   <= maby_q;
						op_b_q[1]   <= '0;
						mul_start_q <= 1'b1;
						state_q     <= S_MUL2;
					end else if (dot_q[LW-1:0] >= len2_q) begin
						op_a_q[0]   <= mabx_q;
						op_b_q[0]   <= MW'(pnsh_pkg::T_ONE);
						op_a_q[1]   <= maby_q;
						op_b_q[1]   <= MW'(pnsh_pkg::T_ONE);
						mul_start_q <= 1'b1;
						state_q     <= S_MUL2;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						op_a_q[0]   <= mabx_q;
						op_b_q[0]   <= MW'(quo);
						op_a_q[1]   <= maby_q;
						op_b_q[1]   <= MW'(quo);
						mul_start_q <= 1'b1;
						state_q     <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (&mul_done) begin
						offx_q  <= off_of(prod[0], abx_neg_q);
						offy_q  <= off_of(prod[1], aby_neg_q);
						state_q <= S_DELTA;
					end
				end
				S_DELTA: begin
					op_a_q[0]   <= mag_of(dx_c);
					op_b_q[0]   <= mag_of(dx_c);
					op_a_q[1]   <= mag_of(dy_c);
					op_b_q[1]   <= mag_of(dy_c);
					mul_start_q <= 1'b1;
					state_q     <= S_MUL3;
				end
				S_MUL3: begin
					if (&mul_done) begin
						dist_q  <= LW'(prod[0]) + LW'(prod[1]);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done    = done_q;
	assign dist_sq = dist_q;

endmodule

>>> rtl/polyline_nearest_segment_hit.sv
`timescale 1ns / 1ps
// Top level of the polyline hit test: handshakes, registers, running best segment.
//
// A start transaction loads the query point (x, y in 1/16 pixel) and clears the
// running state; each vertex transaction closes a segment with the previous
// vertex, and the vertex marked last yields one result (hit, segment_index).
// A vertex that closes a segment with two valid ends keeps the block busy while
// the segment evaluator runs three passes of its 4-bit-digit serial multipliers
// plus the sequencing steps around them, with a restoring division after the
// first pass unless the projection parameter clamps to 0 or 1. Any other
// transaction is taken in the idle state. Every last vertex then passes through
// a result state that loads the result register, which waits there until taken;
// the block keeps accepting input meanwhile, but a further last vertex stalls
// until the slot is free. Vertices beyond min(MAX_POINTS, 65536) in one polyline
// are ignored except for their last mark. Configuration writes are taken on any
// cycle.
module polyline_nearest_segment_hit #(
	parameter int MAX_POINTS = pnsh_pkg::DEF_MAX_POINTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                mode,
	input  logic signed [pnsh_pkg::COORD_W-1:0] coord_x,
	input  logic signed [pnsh_pkg::COORD_W-1:0] coord_y,
	input  logic                                point_ok,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic [pnsh_pkg::SEG_W-1:0]          segment_index,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pnsh_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pnsh_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CNT_LIMIT = (MAX_POINTS < pnsh_pkg::SEG_LIMIT) ? MAX_POINTS
	                                                             : pnsh_pkg::SEG_LIMIT;
	localparam int CNT_W = $clog2(CNT_LIMIT + 1);
	localparam logic [CNT_W-1:0] CNT_LIM_V = CNT_W'(CNT_LIMIT);
	localparam int LW    = pnsh_pkg::LEN_W;
	localparam int TW    = pnsh_pkg::TH_W;
	localparam int SW    = pnsh_pkg::THSQ_W;

	typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_RESULT} state_t;

	state_t                           state_q;
	logic [pnsh_pkg::LW_W-1:0]        line_width_q;
	logic                             enable_q;
	logic [SW-1:0]                    th_sq_q;
	logic signed [pnsh_pkg::COORD_W-1:0] query_x_q, query_y_q, prev_x_q, prev_y_q;
	logic                             prev_ok_q;
	logic [CNT_W-1:0]                 count_q;
	logic [LW-1:0]                    best_dist_q;
	logic [pnsh_pkg::SEG_W-1:0]       best_seg_q;
	logic                             found_q;
	logic                             pend_last_q;
	logic                             eval_start_q;
	pnsh_pkg::seg_req_t               req_q;
	logic                             out_valid_q;
	logic                             hit_q;
	logic [pnsh_pkg::SEG_W-1:0]       seg_q;

	logic                             eval_done;
	logic [LW-1:0]                    eval_dist;
	logic [TW-1:0]                    th_c;
	logic                             room;
	logic                             better;
	logic                             load_res;

	assign th_c = ((line_width_q > pnsh_pkg::LW_W'(pnsh_pkg::HIT_MIN))
	               ? TW'(line_width_q) : TW'(pnsh_pkg::HIT_MIN)) + TW'(pnsh_pkg::HIT_PAD);
	assign room   = count_q < CNT_LIM_V;
	assign better = (eval_dist < LW'(th_sq_q)) && (!found_q || eval_dist < best_dist_q);
	// result slot free or being emptied this cycle
	assign load_res = (state_q == ST_RESULT) && (!out_valid_q || out_ready);

	pnsh_seg_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (eval_start_q),
		.req     (req_q),
		.done    (eval_done),
		.dist_sq (eval_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			line_width_q <= pnsh_pkg::LW_RESET;
			enable_q     <= 1'b1;
			th_sq_q      <= '0;
			query_x_q    <= '0;
			query_y_q    <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			prev_ok_q    <= 1'b0;
			count_q      <= '0;
			best_dist_q  <= '0;
			best_seg_q   <= '0;
			found_q      <= 1'b0;
			pend_last_q  <= 1'b0;
			eval_start_q <= 1'b0;
			req_q        <= '0;
			out_valid_q  <= 1'b0;
			hit_q        <= 1'b0;
			seg_q        <= '0;
		end else begin
			th_sq_q      <= SW'(th_c) * SW'(th_c);
			eval_start_q <= 1'b0;

			if (cfg_valid) begin
				unique case (cfg_index)
					pnsh_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data;
					pnsh_pkg::REG_ENABLE:     enable_q     <= cfg_data[0];
				endcase
			end

			if (load_res)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (mode == pnsh_pkg::MODE_START) begin
							query_x_q <= coord_x;
							query_y_q <= coord_y;
							count_q   <= '0;
							prev_ok_q <= 1'b0;
							found_q   <= 1'b0;
						end else if (room && count_q != '0 && prev_ok_q && point_ok) begin
							req_q.ax     <= prev_x_q;
							req_q.ay     <= prev_y_q;
							req_q.bx     <= coord_x;
							req_q.by     <= coord_y;
							req_q.qx     <= query_x_q;
							req_q.qy     <= query_y_q;
							pend_last_q  <= last;
							eval_start_q <= 1'b1;
							state_q      <= ST_EVAL;
						end else begin
							if (room) begin
								prev_x_q  <= coord_x;
								prev_y_q  <= coord_y;
								prev_ok_q <= point_ok;
								count_q   <= count_q + 1'b1;
							end
							if (last)
								state_q <= ST_RESULT;
						end
					end
				end
				ST_EVAL: begin
					if (eval_done) begin
						if (better) begin
							best_dist_q <= eval_dist;
							best_seg_q  <= pnsh_pkg::SEG_W'(count_q - 1'b1);
							found_q     <= 1'b1;
						end
						prev_x_q  <= req_q.bx;
						prev_y_q  <= req_q.by;
						prev_ok_q <= 1'b1;
						count_q   <= count_q + 1'b1;
						state_q   <= pend_last_q ? ST_RESULT : ST_IDLE;
					end
				end
				ST_RESULT: begin
					if (load_res) begin
						hit_q       <= found_q && enable_q;
						seg_q       <= (found_q && enable_q) ? best_seg_q : '0;
						count_q     <= '0;
						prev_ok_q   <= 1'b0;
						found_q     <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign segment_index = seg_q;

endmodule

>>> tb/sv/polyline_nearest_segment_hit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the polyline hit test, with its own nearest-segment predictor.
module polyline_nearest_segment_hit_tb;
	import pnsh_pkg::*;

	localparam int IDLE_PCT      = 14;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int PHASE_ITEMS   = 220;
	localparam int N_PHASES      = 8;
	localparam int VERT_CAP      = (DEF_MAX_POINTS < SEG_LIMIT) ? DEF_MAX_POINTS : SEG_LIMIT;

	localparam logic signed [COORD_W-1:0] C_MAX = 20'sh7FFFF;
	localparam logic signed [COORD_W-1:0] C_MIN = 20'sh80000;

	typedef struct packed {
		logic             hit;
		logic [SEG_W-1:0] seg;
	} hit_res_t;

	localparam hit_res_t NO_HIT   = '{hit: 1'b0, seg: '0};
	localparam hit_res_t HIT_SEG0 = '{hit: 1'b1, seg: '0};

	typedef struct packed {
		logic                      m;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      ok;
		logic                      lst;
		logic                      typed;
		hit_res_t                  want;
	} dir_row_t;

	localparam int N_DIR = 23;
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		// single vertex after reset: no segment
		'{MODE_VERTEX, 20'sd100, 20'sd100, 1'b1, 1'b1, 1'b1, NO_HIT},
		// start with last set gives nothing
		'{MODE_START, 20'sd0, 20'sd0, 1'b1, 1'b1, 1'b0, NO_HIT},
		'{MODE_VERTEX, -20'sd160, 20'sd0, 1'b1, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, 20'sd160, 20'sd0, 1'b1, 1'b1, 1'b1, HIT_SEG0},
		// coordinate extremes
		'{MODE_START, C_MAX, C_MAX, 1'b0, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, C_MAX, C_MIN, 1'b1, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, C_MIN, C_MAX, 1'b1, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, C_MIN, C_MIN, 1'b1, 1'b1, 1'b0, NO_HIT},
		// degenerate segment on the query, then an invalid end
		'{MODE_START, C_MIN, C_MIN, 1'b0, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, C_MIN, C_MIN, 1'b1, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, C_MIN, C_MIN, 1'b1, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, C_MIN, 20'sh8007F, 1'b0, 1'b1, 1'b1, HIT_SEG0},
		// just inside the threshold, equal distance does not replace, later better segment
		'{MODE_START, 20'sd0, 20'sd0, 1'b0, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, 20'sd0, 20'sd127, 1'b1, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, 20'sd0, 20'sd127, 1'b1, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, 20'sd0, 20'sd128, 1'b1, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, -20'sd200, 20'sd50, 1'b0, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, 20'sd200, -20'sd50, 1'b1, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, -20'sd200, -20'sd60, 1'b1, 1'b1, 1'b0, NO_HIT},
		// new polyline against the kept query point
		'{MODE_VERTEX, 20'sd16, 20'sd16, 1'b1, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, -20'sd16, -20'sd16, 1'b1, 1'b1, 1'b1, HIT_SEG0},
		'{MODE_VERTEX, C_MAX, 20'sd0, 1'b1, 1'b0, 1'b0, NO_HIT},
		'{MODE_VERTEX, C_MIN, 20'sd0, 1'b1, 1'b1, 1'b0, NO_HIT}
	};

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      in_valid      = 1'b0;
	logic                      in_ready;
	logic                      mode          = MODE_START;
	logic signed [COORD_W-1:0] coord_x       = '0;
	logic signed [COORD_W-1:0] coord_y       = '0;
	logic                      point_ok      = 1'b0;
	logic                      last          = 1'b0;
	logic                      out_valid;
	logic                      out_ready     = 1'b0;
	logic                      hit;
	logic [SEG_W-1:0]          segment_index;
	logic                      cfg_valid     = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index     = REG_LINE_WIDTH;
	logic [CFG_DATA_W-1:0]     cfg_data      = '0;

	// predictor state and its copy of the registers
	logic signed [COORD_W-1:0] qry_x, qry_y, prv_x, prv_y;
	logic                      prv_ok;
	logic [SEG_W:0]            vtx_count;
	longint unsigned           best_d2;
	logic [SEG_W-1:0]          best_idx;
	logic                      have_best;
	logic [LW_W-1:0]           lw_reg;
	logic                      en_reg;

	hit_res_t pending_hits[$];
	hit_res_t oldest;
	bit       no_idle = 1'b0;
	int       n_err = 0, n_items = 0, n_results = 0, n_hits = 0, n_writes = 0, n_cycles = 0;

	polyline_nearest_segment_hit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.point_ok     (point_ok),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.segment_index(segment_index),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still pending", $time, pending_hits.size());
			$display("polyline_nearest_segment_hit_tb: done, errors");
			$finish;
		end
	end

	function automatic void restart_polyline();
		prv_x     = '0;
		prv_y     = '0;
		prv_ok    = 1'b0;
		vtx_count = '0;
		best_d2   = 0;
		best_idx  = '0;
		have_best = 1'b0;
	endfunction

	// squared distance from the query point to segment a-b, t truncated to Q0.16
	function automatic longint unsigned dist_to_segment_sq(longint ax, longint ay,
			longint bx, longint by);
		longint          abx, aby, dot, cx, cy, dx, dy;
		longint unsigned len2, t;
		abx  = bx - ax;
		aby  = by - ay;
		len2 = abx * abx + aby * aby;
		dot  = (longint'(qry_x) - ax) * abx + (longint'(qry_y) - ay) * aby;
		if (len2 == 0 || dot <= 0)
			t = 0;
		else if (unsigned'(dot) >= len2)
			t = 64'd1 << T_FRAC;
		else
			t = (unsigned'(dot) << T_FRAC) / len2;
		// arithmetic shift floors toward minus infinity
		cx = ax + ((abx * longint'(t)) >>> T_FRAC);
		cy = ay + ((aby * longint'(t)) >>> T_FRAC);
		dx = longint'(qry_x) - cx;
		dy = longint'(qry_y) - cy;
		return dx * dx + dy * dy;
	endfunction

	function automatic bit predict_nearest(input logic m, input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y, input logic ok, input logic lst,
			output hit_res_t res);
		longint unsigned d2, th;
		res = NO_HIT;
		if (m == MODE_START) begin
			qry_x = x;
			qry_y = y;
			restart_polyline();
			return 1'b0;
		end
		if (vtx_count < VERT_CAP) begin
			if (vtx_count != 0 && prv_ok && ok) begin
				th = ((lw_reg > HIT_MIN) ? lw_reg : HIT_MIN) + HIT_PAD;
				d2 = dist_to_segment_sq(prv_x, prv_y, x, y);
				if (d2 < th * th && (!have_best || d2 < best_d2)) begin
					best_d2   = d2;
					best_idx  = SEG_W'(vtx_count - 1);
					have_best = 1'b1;
				end
			end
			prv_x  = x;
			prv_y  = y;
			prv_ok = ok;
			vtx_count++;
		end
		if (!lst)
			return 1'b0;
		if (have_best && en_reg)
			res = '{hit: 1'b1, seg: best_idx};
		restart_polyline();
		return 1'b1;
	endfunction

	function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] c,
			int spread);
		longint v;
		v = longint'(c) + longint'($urandom_range(2 * spread)) - spread;
		if (v > longint'(C_MAX))
			v = C_MAX;
		if (v < longint'(C_MIN))
			v = C_MIN;
		return COORD_W'(v);
	endfunction

	task automatic send_item(input logic m, input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y, input logic ok, input logic lst,
			input bit typed = 1'b0, input hit_res_t typed_res = NO_HIT);
		hit_res_t res;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		coord_x  <= x;
		coord_y  <= y;
		point_ok <= ok;
		last     <= lst;
		do @(posedge clk); while (!in_ready);
		n_items++;
		if (predict_nearest(m, x, y, ok, lst, res))
			pending_hits.push_back(typed ? typed_res : res);
	endtask

	// hold input until all results are out and the segment evaluator has drained
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LINE_WIDTH: lw_reg = data;
			REG_ENABLE:     en_reg = data[0];
		endcase
		n_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_results++;
				if (pending_hits.size() == 0) begin
					n_err++;
					$display("%0t: unexpected result, expected none, got hit %0d segment %0d",
						$time, hit, segment_index);
				end else begin
					oldest = pending_hits.pop_front();
					if (oldest.hit)
						n_hits++;
					if (hit !== oldest.hit) begin
						n_err++;
						$display("%0t: hit mismatch, expected %0d, got %0d",
							$time, oldest.hit, hit);
					end
					if (segment_index !== oldest.seg) begin
						n_err++;
						$display("%0t: segment_index mismatch, expected %0d, got %0d",
							$time, oldest.seg, segment_index);
					end
				end
			end
			out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		logic signed [COORD_W-1:0] qx, qy;
		logic [LW_W-1:0]           lw_new;
		int                        phase_end, n_v, spread, th_now, pick;
		lw_reg = LW_RESET;
		en_reg = 1'b1;
		qry_x  = '0;
		qry_y  = '0;
		restart_polyline();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_item(DIR_ROWS[i].m, DIR_ROWS[i].x, DIR_ROWS[i].y, DIR_ROWS[i].ok,
				DIR_ROWS[i].lst, DIR_ROWS[i].typed, DIR_ROWS[i].want);

		qx = '0;
		qy = '0;
		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			case (p)
				0:       lw_new = '0;
				1, 4:    lw_new = '1;
				2:       lw_new = LW_W'(HIT_MIN);
				3:       lw_new = LW_W'(HIT_MIN + 1);
				default: lw_new = LW_W'($urandom);
			endcase
			write_reg(REG_LINE_WIDTH, lw_new);
			// enable rides in bit 0, upper data bits are don't-care
			write_reg(REG_ENABLE, {9'($urandom), (p == 3 || p == 4) ? 1'b0 : 1'b1});
			no_idle   = (p == 2);
			phase_end = n_items + PHASE_ITEMS;
			while (n_items < phase_end) begin
				pick = $urandom_range(99);
				if (pick < 10) begin
					send_item(1'($urandom_range(1)), 20'($urandom), 20'($urandom),
						1'($urandom_range(1)), 1'($urandom_range(1)));
				end else begin
					// most polylines get a fresh query, some reuse the kept one
					if (pick < 75) begin
						if ($urandom_range(9) == 0) begin
							qx = $urandom_range(1) ? C_MAX : C_MIN;
							qy = $urandom_range(1) ? C_MAX : C_MIN;
						end else begin
							qx = 20'($urandom);
							qy = 20'($urandom);
						end
						send_item(MODE_START, qx, qy, 1'($urandom_range(1)),
							1'($urandom_range(1)));
					end
					th_now = ((lw_reg > HIT_MIN) ? lw_reg : HIT_MIN) + HIT_PAD;
					case ($urandom_range(3))
						0:       spread = th_now / 2;
						1:       spread = th_now;
						2:       spread = 4 * th_now;
						default: spread = 1 << (COORD_W - 1);
					endcase
					n_v = $urandom_range(1, 8);
					for (int v = 0; v < n_v; v++) begin
						if (v != 0 && $urandom_range(24) == 0)
							send_item(MODE_START, qx, qy, 1'b1, 1'b0);
						send_item(MODE_VERTEX, near_coord(qx, spread), near_coord(qy, spread),
							$urandom_range(99) < 88, v == n_v - 1);
						// threshold change between two vertices of one polyline
						if (v != n_v - 1 && $urandom_range(150) == 0) begin
							wait_idle();
							write_reg(REG_LINE_WIDTH, LW_W'($urandom));
						end
					end
				end
			end
		end
		no_idle = 1'b0;

		wait_idle();
		$display("coverage: %0d input transactions, %0d results of which %0d hits, %0d writes",
			n_items, n_results, n_hits, n_writes);
		$display("coverage: directed corner rows plus %0d threshold/enable phases of polylines",
			N_PHASES);
		if (n_err == 0)
			$display("polyline_nearest_segment_hit_tb: done, clean");
		else
			$display("polyline_nearest_segment_hit_tb: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
rtl/pnsh_pkg.sv
rtl/pnsh_ser_mul.sv
rtl/pnsh_div.sv
rtl/pnsh_seg_eval.sv
rtl/polyline_nearest_segment_hit.sv
tb/sv/polyline_nearest_segment_hit_tb.sv
